/* hdl/stc_pkg.sv */
package stc_pkg;

    localparam int STORE_DEPTH_DEF = 128;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths of the stream payload and of the configuration registers.
    localparam int CMD_BITS        = 2;
    localparam int READ_INDEX_BITS = 7;
    localparam int FILL_BITS       = 8;
    localparam int INTERVAL_BITS   = 8;
    localparam int GAIN_BITS       = 16;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_INTERVAL = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN            = 1'd1;

    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 8'd1;
    localparam logic [GAIN_BITS-1:0]     GAIN_RESET     = 16'd4096;

    // Gain is unsigned Q4.12; results are rounded half up.
    localparam int GAIN_FRAC  = 12;
    localparam int ROUND_HALF = 1 << (GAIN_FRAC - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DEPTH   = 4;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_REARM = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_IGNORE  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic                 entry_valid;
        logic                 full_event;
        logic [FILL_BITS-1:0] fill_count;
    } op_ctrl_t;

endpackage

/* hdl/stc_ram.sv */
module stc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

/* hdl/stc_fifo.sv */
module stc_fifo
    import stc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             not_empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign dout      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* hdl/stc_front.sv */
module stc_front
    import stc_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    input  logic [CMD_BITS-1:0]              cmd,
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    input  logic                             eob,
    input  logic [READ_INDEX_BITS-1:0]       read_index,
    input  logic [INTERVAL_BITS-1:0]         sample_interval,
    output op_ctrl_t                         op_ctrl,
    output logic signed [SAMPLE_BITS-1:0]    op_sample,
    output logic [$clog2(STORE_DEPTH)-1:0]   op_addr
);

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int WPW = $clog2(STORE_DEPTH + 1);

    phase_t                        phase_reg, phase_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [INTERVAL_BITS-1:0]      stride_reg, stride_next;
    logic [WPW-1:0]                wp_reg, wp_next;
    // Entries below the high-water mark have been written since reset.
    logic [WPW-1:0]                hw_reg, hw_next;

    logic [INTERVAL_BITS-1:0] stride_eff;
    logic [INTERVAL_BITS-1:0] stride_inc;
    logic                     prev_pos, prev_neg, cur_pos, cur_neg;
    logic                     trig;
    logic                     attempt;

    assign stride_eff = (sample_interval == '0) ? INTERVAL_BITS'(1) : sample_interval;
    assign stride_inc = stride_reg + 1'b1;
    assign prev_neg   = prev_reg[SAMPLE_BITS-1];
    assign prev_pos   = !prev_reg[SAMPLE_BITS-1] && (prev_reg != '0);
    assign cur_neg    = sample[SAMPLE_BITS-1];
    assign cur_pos    = !sample[SAMPLE_BITS-1] && (sample != '0);
    assign trig       = (prev_pos && cur_neg) || (prev_neg && cur_pos);
    assign op_sample  = sample;

    always_comb begin
        phase_next          = phase_reg;
        prev_next           = prev_reg;
        stride_next         = stride_reg;
        wp_next             = wp_reg;
        hw_next             = hw_reg;
        attempt             = 1'b0;
        op_addr             = '0;
        op_ctrl.kind        = OP_NONE;
        op_ctrl.entry_valid = 1'b0;
        op_ctrl.full_event  = 1'b0;
        if (in_valid) begin
            case (cmd_t'(cmd))
                CMD_PUSH: begin
                    case (phase_reg)
                        PH_SEARCH: begin
                            if (trig) begin
                                phase_next = PH_CAPTURE;
                                attempt    = 1'b1;
                            end
                            prev_next = sample;
                        end
                        PH_CAPTURE: begin
                            stride_next = stride_inc;
                            if (stride_inc >= stride_eff) begin
                                attempt = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (attempt) begin
                        if (wp_reg >= WPW'(STORE_DEPTH)) begin
                            phase_next         = PH_IGNORE;
                            op_ctrl.full_event = 1'b1;
                        end else begin
                            op_ctrl.kind = OP_WRITE;
                            op_addr      = AW'(wp_reg);
                            wp_next      = wp_reg + 1'b1;
                            stride_next  = '0;
                            if (wp_next > hw_reg) begin
                                hw_next = wp_next;
                            end
                        end
                    end
                    if (eob) begin
                        phase_next  = PH_SEARCH;
                        prev_next   = '0;
                        stride_next = '0;
                    end
                end
                CMD_READ: begin
                    op_ctrl.kind        = OP_READ;
                    op_addr             = AW'(read_index);
                    op_ctrl.entry_valid = (32'(read_index) < 32'(hw_reg));
                end
                CMD_REARM: begin
                    wp_next = '0;
                end
                default: begin
                end
            endcase
        end
        op_ctrl.fill_count = FILL_BITS'(wp_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEARCH;
            prev_reg   <= '0;
            stride_reg <= '0;
            wp_reg     <= '0;
            hw_reg     <= '0;
        end else begin
            phase_reg  <= phase_next;
            prev_reg   <= prev_next;
            stride_reg <= stride_next;
            wp_reg     <= wp_next;
            hw_reg     <= hw_next;
        end
    end

endmodule

/* hdl/stc_back.sv */
module stc_back
    import stc_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  op_ctrl_t                       q_ctrl,
    input  logic signed [SAMPLE_BITS-1:0]  q_sample,
    input  logic [$clog2(STORE_DEPTH)-1:0] q_addr,
    input  logic [GAIN_BITS-1:0]           gain,
    input  logic                           out_pop,
    output logic                           q_pop,
    output logic                           res_valid,
    output logic [SAMPLE_BITS-1:0]         res_read_data,
    output logic                           res_full_event,
    output logic [FILL_BITS-1:0]           res_fill_count
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int PW    = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int OCW   = $clog2(OUT_DEPTH + 1);
    localparam logic signed [PW-1:0] SAT_HI = PW'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

    // Items issued to the pipeline and not yet taken from the output queue.
    logic [OCW-1:0] outstanding_reg, outstanding_next;

    logic                   s1_valid_reg;
    op_ctrl_t               s1_ctrl_reg;
    logic [AW-1:0]          s1_addr_reg;
    logic signed [PW-1:0]   s1_prod_reg;
    logic                   s2_valid_reg;
    op_ctrl_t               s2_ctrl_reg;

    logic signed [PW-1:0]    rounded;
    logic signed [PW-1:0]    shifted;
    logic [SAMPLE_BITS-1:0]  sat_val;
    logic [SAMPLE_BITS-1:0]  ram_q;
    logic                    ram_we;

    assign q_pop = q_valid && (outstanding_reg < OCW'(OUT_DEPTH));

    always_comb begin
        outstanding_next = outstanding_reg;
        if (q_pop && !out_pop) begin
            outstanding_next = outstanding_reg + 1'b1;
        end else if (out_pop && !q_pop) begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    // Round half up, then an arithmetic shift floors toward minus infinity.
    assign rounded = s1_prod_reg + PW'(ROUND_HALF);
    assign shifted = rounded >>> GAIN_FRAC;

    always_comb begin
        if (shifted > SAT_HI) begin
            sat_val = SAT_HI[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            sat_val = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_val = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign ram_we = s1_valid_reg && (s1_ctrl_reg.kind == OP_WRITE);

    stc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_addr_reg),
        .wr_data (sat_val),
        .rd_addr (s1_addr_reg),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
        end else begin
            outstanding_reg <= outstanding_next;
            s1_valid_reg    <= q_pop;
            s2_valid_reg    <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_ctrl_reg <= q_ctrl;
        s1_addr_reg <= q_addr;
        s1_prod_reg <= q_sample * $signed({1'b0, gain});
        s2_ctrl_reg <= s1_ctrl_reg;
    end

    assign res_valid      = s2_valid_reg;
    assign res_read_data  = ((s2_ctrl_reg.kind == OP_READ) && s2_ctrl_reg.entry_valid)
                            ? ram_q : '0;
    assign res_full_event = s2_ctrl_reg.full_event;
    assign res_fill_count = s2_ctrl_reg.fill_count;

endmodule

/* hdl/scope_trigger_capture.sv */
// An item passes the input queue, back-end stages s1 and s2, and the output queue.
// Throughput: one item per cycle unless m_tready stalls; the front state update, one
// 16x17 multiply stage and one capture RAM port each handle a single item per cycle.
// Reset (aresetn, synchronous, active low) clears the trigger state, the write
// position and the written-entry mark, so the whole store reads as zero.
module scope_trigger_capture
    import stc_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IN_W  = ((CMD_BITS + SAMPLE_BITS + READ_INDEX_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + 1 + FILL_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command, sample, read_index from bit 0 up, zero padded
    input  logic [IN_W-1:0]       s_tdata,
    // end_of_block
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_data, full_event, fill_count from bit 0 up, zero padded
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int CTRL_W = $bits(op_ctrl_t);
    localparam int Q_W    = CTRL_W + AW + SAMPLE_BITS;
    localparam int R_W    = SAMPLE_BITS + 1 + FILL_BITS;

    logic [INTERVAL_BITS-1:0] interval_reg;
    logic [GAIN_BITS-1:0]     gain_reg;

    logic                          s_accept;
    op_ctrl_t                      f_ctrl;
    logic signed [SAMPLE_BITS-1:0] f_sample;
    logic [AW-1:0]                 f_addr;

    logic [Q_W-1:0]                q_dout;
    logic                          q_not_empty;
    logic                          q_full;
    logic                          q_pop;
    op_ctrl_t                      q_ctrl;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic [AW-1:0]                 q_addr;

    logic                   res_valid;
    logic [SAMPLE_BITS-1:0] res_read_data;
    logic                   res_full_event;
    logic [FILL_BITS-1:0]   res_fill_count;
    logic [R_W-1:0]         o_dout;
    logic                   o_full;
    logic                   o_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
            gain_reg     <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SAMPLE_INTERVAL: interval_reg <= cfg_wdata[INTERVAL_BITS-1:0];
                REG_GAIN:            gain_reg     <= cfg_wdata[GAIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    stc_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_accept),
        .cmd             (s_tdata[CMD_BITS-1:0]),
        .sample          (s_tdata[CMD_BITS+SAMPLE_BITS-1:CMD_BITS]),
        .eob             (s_tlast),
        .read_index      (s_tdata[CMD_BITS+SAMPLE_BITS+READ_INDEX_BITS-1:
                                  CMD_BITS+SAMPLE_BITS]),
        .sample_interval (interval_reg),
        .op_ctrl         (f_ctrl),
        .op_sample       (f_sample),
        .op_addr         (f_addr)
    );

    stc_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .din       ({f_ctrl, f_addr, f_sample}),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    assign q_sample = q_dout[SAMPLE_BITS-1:0];
    assign q_addr   = q_dout[SAMPLE_BITS+AW-1:SAMPLE_BITS];
    assign q_ctrl   = op_ctrl_t'(q_dout[Q_W-1:SAMPLE_BITS+AW]);

    stc_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_not_empty),
        .q_ctrl         (q_ctrl),
        .q_sample       (q_sample),
        .q_addr         (q_addr),
        .gain           (gain_reg),
        .out_pop        (o_pop),
        .q_pop          (q_pop),
        .res_valid      (res_valid),
        .res_read_data  (res_read_data),
        .res_full_event (res_full_event),
        .res_fill_count (res_fill_count)
    );

    // The back end issues only against free output slots, so this never overflows.
    stc_fifo #(
        .WIDTH (R_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .din       ({res_fill_count, res_full_event, res_read_data}),
        .pop       (o_pop),
        .dout      (o_dout),
        .not_empty (m_tvalid),
        .full      (o_full)
    );

    assign o_pop   = m_tvalid && m_tready && !(o_full && 1'b0);
    assign m_tdata = OUT_W'(o_dout);

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stc_pkg::*;

    localparam int DEPTH        = 128;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 115;
    localparam int NUM_PHASES   = 7;
    localparam int NUM_DIRECTED = 23;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_BITS-1:0]        cmd;
        logic [15:0]                smp;
        logic                       last;
        logic [READ_INDEX_BITS-1:0] idx;
        bit                         has_exp;
        logic [15:0]                exp_data;
        logic                       exp_full;
        logic [FILL_BITS-1:0]       exp_fill;
    } stim_row_t;

    typedef struct {
        logic [15:0]          read_data;
        logic                 full_event;
        logic [FILL_BITS-1:0] fill_count;
    } capture_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;

    scope_trigger_capture u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Shadow copy of the trigger and capture state.
    logic [INTERVAL_BITS-1:0] cfg_interval = INTERVAL_RESET;
    logic [GAIN_BITS-1:0]     cfg_gain     = GAIN_RESET;
    logic signed [15:0]       prev_smp     = '0;
    phase_t                   trig_phase   = PH_SEARCH;
    int                       stride_cnt   = 0;
    int                       wr_pos       = 0;
    logic [15:0]              capture_mem [DEPTH];

    capture_result_t pending_results [$];
    int              fail_count  = 0;
    int              cycle_count = 0;
    int              burst_left  = 0;

    function automatic logic [15:0] scale_sample(input logic signed [15:0] s);
        longint prod;
        prod = longint'(s) * longint'(cfg_gain) + longint'(ROUND_HALF);
        prod = prod >>> GAIN_FRAC;
        if (prod > 32767)
            prod = 32767;
        if (prod < -32768)
            prod = -32768;
        return prod[15:0];
    endfunction

    // Returns 1 when the store had no room left.
    function automatic bit store_capture(input logic signed [15:0] s);
        if (wr_pos >= DEPTH) begin
            trig_phase = PH_IGNORE;
            return 1'b1;
        end
        capture_mem[wr_pos] = scale_sample(s);
        wr_pos++;
        stride_cnt = 0;
        return 1'b0;
    endfunction

    function automatic capture_result_t predict_capture(input stim_row_t r);
        capture_result_t res;
        logic signed [15:0] s;
        int stride;
        bit trig;
        res.read_data  = '0;
        res.full_event = 1'b0;
        case (r.cmd)
            CMD_PUSH: begin
                s = r.smp;
                stride = (cfg_interval == 0) ? 1 : int'(cfg_interval);
                if (trig_phase == PH_SEARCH) begin
                    trig = (prev_smp > 0 && s < 0) || (prev_smp < 0 && s > 0);
                    if (trig) begin
                        trig_phase = PH_CAPTURE;
                        if (store_capture(s))
                            res.full_event = 1'b1;
                    end
                    prev_smp = s;
                end else if (trig_phase == PH_CAPTURE) begin
                    stride_cnt++;
                    if (stride_cnt >= stride && store_capture(s))
                        res.full_event = 1'b1;
                end
                if (r.last) begin
                    trig_phase = PH_SEARCH;
                    prev_smp   = '0;
                    stride_cnt = 0;
                end
            end
            CMD_READ: begin
                res.read_data = capture_mem[r.idx];
            end
            CMD_REARM: begin
                wr_pos = 0;
            end
            default: begin
            end
        endcase
        res.fill_count = FILL_BITS'(wr_pos);
        return res;
    endfunction

    function automatic stim_row_t dir_row(input logic [CMD_BITS-1:0] cmd,
                                          input logic [15:0] smp, input logic last,
                                          input logic [READ_INDEX_BITS-1:0] idx,
                                          input bit has_exp, input logic [15:0] data,
                                          input logic full, input logic [FILL_BITS-1:0] fill);
        stim_row_t r;
        r.cmd      = cmd;
        r.smp      = smp;
        r.last     = last;
        r.idx      = idx;
        r.has_exp  = has_exp;
        r.exp_data = data;
        r.exp_full = full;
        r.exp_fill = fill;
        return r;
    endfunction

    // Drives one item; when a burst runs out, a new one starts, most often after a random gap.
    task automatic send_item(input stim_row_t r);
        int gap;
        capture_result_t want;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(30, 120);
            end else begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, r.idx, r.smp, r.cmd};
        s_tlast  <= r.last;
        do
            @(posedge aclk);
        while (!s_tready);
        want = predict_capture(r);
        if (r.has_exp) begin
            want.read_data  = r.exp_data;
            want.full_event = r.exp_full;
            want.fill_count = r.exp_fill;
        end
        pending_results.push_back(want);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] interval, input logic [15:0] gain_val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_SAMPLE_INTERVAL;
        cfg_wdata <= {8'b0, interval};
        @(posedge aclk);
        cfg_addr  <= REG_GAIN;
        cfg_wdata <= gain_val;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        cfg_interval  = interval;
        cfg_gain      = gain_val;
    endtask

    function automatic logic [15:0] wave_sample(input bit neg);
        int mag;
        case ($urandom_range(0, 9))
            0:       mag = 0;
            1:       mag = 32768;
            2, 3:    mag = $urandom_range(1, 8);
            default: mag = $urandom_range(1, 32768);
        endcase
        if (!neg && mag > 32767)
            mag = 32767;
        return neg ? 16'(-mag) : 16'(mag);
    endfunction

    // Receiver stalls follow one of four modes, redrawn at random as stall_timer runs.
    int stall_mode  = 0;
    int stall_timer = 0;
    always @(posedge aclk) begin
        stall_timer++;
        if (stall_timer % 150 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ((stall_timer % 7) < 4);
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge aclk) begin : result_check
        capture_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.read_data) begin
                    $error("read_data: expected %h, actual %h", want.read_data, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[16] !== want.full_event) begin
                    $error("full_event: expected %b, actual %b", want.full_event, m_tdata[16]);
                    fail_count++;
                end
                if (m_tdata[24:17] !== want.fill_count) begin
                    $error("fill_count: expected %0d, actual %0d", want.fill_count,
                           m_tdata[24:17]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        stim_row_t   directed_rows [NUM_DIRECTED];
        stim_row_t   r;
        logic [7:0]  phase_interval [NUM_PHASES];
        logic [15:0] phase_gain [NUM_PHASES];
        int items, block_len, period, pick;
        bit wave, neg;

        for (int i = 0; i < DEPTH; i++)
            capture_mem[i] = '0;

        // After reset everything reads as zero; a block's first sample never
        // triggers, and a zero between two signs breaks the crossing.
        directed_rows[0]  = dir_row(CMD_READ,   16'h0000, 1'b0, 7'd0,   1, 16'h0000, 0, 8'd0);
        directed_rows[1]  = dir_row(CMD_READ,   16'h0000, 1'b0, 7'd127, 1, 16'h0000, 0, 8'd0);
        directed_rows[2]  = dir_row(CMD_UNUSED, 16'h7fff, 1'b1, 7'd127, 1, 16'h0000, 0, 8'd0);
        directed_rows[3]  = dir_row(CMD_PUSH,   16'd100,  1'b0, 7'd0,   1, 16'h0000, 0, 8'd0);
        directed_rows[4]  = dir_row(CMD_PUSH,   16'h8000, 1'b0, 7'd0,   1, 16'h0000, 0, 8'd1);
        directed_rows[5]  = dir_row(CMD_PUSH,   16'h7fff, 1'b0, 7'd0,   1, 16'h0000, 0, 8'd2);
        directed_rows[6]  = dir_row(CMD_PUSH,   16'h0000, 1'b1, 7'd0,   1, 16'h0000, 0, 8'd3);
        directed_rows[7]  = dir_row(CMD_PUSH,   16'd5,    1'b0, 7'd0,   1, 16'h0000, 0, 8'd3);
        directed_rows[8]  = dir_row(CMD_PUSH,   16'h0000, 1'b0, 7'd0,   1, 16'h0000, 0, 8'd3);
        directed_rows[9]  = dir_row(CMD_PUSH,   16'hfffb, 1'b0, 7'd0,   1, 16'h0000, 0, 8'd3);
        directed_rows[10] = dir_row(CMD_PUSH,   16'd7,    1'b1, 7'd0,   1, 16'h0000, 0, 8'd4);
        directed_rows[11] = dir_row(CMD_PUSH,   16'hfffd, 1'b0, 7'd0,   1, 16'h0000, 0, 8'd4);
        directed_rows[12] = dir_row(CMD_PUSH,   16'd3,    1'b0, 7'd0,   1, 16'h0000, 0, 8'd5);
        directed_rows[13] = dir_row(CMD_PUSH,   16'hfff8, 1'b0, 7'd0,   0, '0, 0, '0);
        directed_rows[14] = dir_row(CMD_PUSH,   16'd9,    1'b1, 7'd0,   0, '0, 0, '0);
        directed_rows[15] = dir_row(CMD_READ,   16'h0000, 1'b0, 7'd0,   1, 16'h8000, 0, 8'd7);
        directed_rows[16] = dir_row(CMD_READ,   16'hffff, 1'b1, 7'd1,   1, 16'h7fff, 0, 8'd7);
        directed_rows[17] = dir_row(CMD_READ,   16'h0000, 1'b0, 7'd2,   1, 16'h0000, 0, 8'd7);
        directed_rows[18] = dir_row(CMD_READ,   16'h0000, 1'b0, 7'd3,   1, 16'h0007, 0, 8'd7);
        directed_rows[19] = dir_row(CMD_READ,   16'h0000, 1'b0, 7'd5,   0, '0, 0, '0);
        directed_rows[20] = dir_row(CMD_REARM,  16'h1234, 1'b0, 7'd64,  1, 16'h0000, 0, 8'd0);
        directed_rows[21] = dir_row(CMD_READ,   16'h0000, 1'b0, 7'd6,   0, '0, 0, '0);
        directed_rows[22] = dir_row(CMD_PUSH,   16'd1,    1'b1, 7'd0,   1, 16'h0000, 0, 8'd0);

        phase_interval[0] = 8'd3;   phase_gain[0] = 16'd8192;
        phase_interval[1] = 8'd0;   phase_gain[1] = 16'hffff;
        phase_interval[2] = 8'd200; phase_gain[2] = 16'd0;
        phase_interval[3] = 8'd255; phase_gain[3] = 16'($urandom);
        phase_interval[4] = 8'($urandom_range(1, 200)); phase_gain[4] = 16'($urandom);
        phase_interval[5] = 8'd1;   phase_gain[5] = 16'd4096;
        phase_interval[6] = 8'd2;   phase_gain[6] = 16'($urandom);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(directed_rows[i]);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            program_regs(phase_interval[ph], phase_gain[ph]);
            items = 0;
            while (items < PHASE_ITEMS) begin
                // Mostly short blocks; now and then one long enough for wide strides.
                block_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 260)
                                                        : $urandom_range(1, 24);
                wave   = ($urandom_range(0, 3) != 0);
                period = $urandom_range(1, 6);
                neg    = $urandom_range(0, 1);
                for (int k = 0; k < block_len && items < PHASE_ITEMS; k++) begin
                    r.has_exp  = 0;
                    r.exp_data = '0;
                    r.exp_full = 1'b0;
                    r.exp_fill = '0;
                    r.idx      = 7'($urandom);
                    pick       = $urandom_range(0, 299);
                    if (pick == 0) begin
                        r.cmd  = CMD_REARM;
                        r.smp  = 16'($urandom);
                        r.last = 1'($urandom);
                    end else if (pick < 30) begin
                        r.cmd  = CMD_READ;
                        r.smp  = 16'($urandom);
                        r.last = 1'($urandom);
                    end else if (pick < 33) begin
                        r.cmd  = CMD_UNUSED;
                        r.smp  = 16'($urandom);
                        r.last = 1'($urandom);
                    end else begin
                        r.cmd = CMD_PUSH;
                        if (wave) begin
                            if (k > 0 && k % period == 0)
                                neg = !neg;
                            r.smp = wave_sample(neg);
                        end else begin
                            r.smp = 16'($urandom);
                        end
                        r.last = (k == block_len - 1);
                    end
                    send_item(r);
                    items++;
                end
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* scope_trigger_capture.f */
hdl/stc_pkg.sv
hdl/stc_ram.sv
hdl/stc_fifo.sv
hdl/stc_front.sv
hdl/stc_back.sv
hdl/scope_trigger_capture.sv
bench/testbench.sv
